// File: rtl/reed_solomon_parity_encoder_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RS parity encoder
// Shared concurrent assertion forms; each use expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef REED_SOLOMON_PARITY_ENCODER_UNIT_MACROS_SVH
`define REED_SOLOMON_PARITY_ENCODER_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rsp_pkg.sv
// ---------------------------------------------------------------------------
// RS parity encoder package
// Beat types, field constants and GF(256) helpers.
// ---------------------------------------------------------------------------
package rsp_pkg;

	localparam logic [8:0] FIELD_POLY  = 9'h11D;
	localparam int         COUNT_LIMIT = 30;
	localparam logic [4:0] RESET_COUNT = 5'd10;

	typedef enum logic {
		REG_PARITY_COUNT = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       block_last;
	} in_t;

	typedef struct packed {
		logic [7:0] parity_byte;
		logic       parity_last;
	} out_t;

	// multiply by alpha
	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY[7:0] : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x   = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc = acc ^ x;
			x = gf_xtime(x);
		end
		return acc;
	endfunction

	// zero acts as one, anything above cap saturates
	function automatic logic [4:0] clamp_count(input logic [4:0] v, input logic [4:0] cap);
		logic [4:0] n;
		n = v;
		if (n == 5'd0)
			n = 5'd1;
		if (n > cap)
			n = cap;
		return n;
	endfunction

endpackage

// File: rtl/reed_solomon_parity_encoder_unit.sv
// ---------------------------------------------------------------------------
// Reed-Solomon parity encoder, GF(256) / 0x11D
// Systematic LFSR encoder with programmable parity count and APB config.
// ---------------------------------------------------------------------------
//  channel  | signals                                  | beat
//  ---------+------------------------------------------+-------------------------
//  in       | in_valid, in_ready, in_data              | data_byte, block_last
//  out      | out_valid, out_ready, out_data           | parity_byte, parity_last
//  config   | psel, penable, pwrite, paddr, pwdata ... | parity_count at 0x0
//
// One data beat per cycle while in_ready is high; the remainder updates in the cycle the beat is taken.
// Each block yields parity_count beats at one per cycle while out_ready is high, from the unload register.
// A two-entry queue lets the next block stream in while earlier parity unloads.
// in_ready also drops while two finished remainders wait behind the one unloading.
// After reset and after each parity_count write, the generator is rebuilt one
// root per cycle; in_ready stays low meanwhile.
// ---------------------------------------------------------------------------
module reed_solomon_parity_encoder_unit #(
	parameter int MAX_PARITY = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rsp_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rsp_pkg::out_t out_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int DEPTH = (MAX_PARITY < rsp_pkg::COUNT_LIMIT) ? MAX_PARITY
	                                                            : rsp_pkg::COUNT_LIMIT;
	localparam int QW    = DEPTH * 8 + 5;

	logic                  cfg_we;
	logic [4:0]            count;
	logic                  push_valid;
	logic                  push_full;
	logic [DEPTH-1:0][7:0] push_vec;
	logic [4:0]            push_cnt;
	logic                  pop;
	logic                  pop_valid;
	logic [QW-1:0]         pop_data;
	rsp_pkg::reg_idx_t     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = rsp_pkg::reg_idx_t'(paddr[2]);
	assign cfg_we  = psel && penable && pwrite && reg_idx == rsp_pkg::REG_PARITY_COUNT;

	always_comb begin
		case (reg_idx)
			rsp_pkg::REG_PARITY_COUNT: prdata = {27'd0, count};
			default:                   prdata = 32'd0;
		endcase
	end

	rsp_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (pwdata[4:0]),
		.count      (count),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_vec   (push_vec),
		.push_cnt   (push_cnt)
	);

	rsp_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data ({push_cnt, push_vec}),
		.full      (push_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.valid     (pop_valid)
	);

	rsp_back #(
		.DEPTH(DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_vec   (pop_data[DEPTH*8-1:0]),
		.pop_cnt   (pop_data[QW-1:DEPTH*8]),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: rtl/rsp_front.sv
// ---------------------------------------------------------------------------
// RS parity encoder front end
// Accepts data beats, runs the LFSR division and rebuilds the generator.
// ---------------------------------------------------------------------------
`include "reed_solomon_parity_encoder_unit_macros.svh"

module rsp_front #(
	parameter int DEPTH = 30
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  rsp_pkg::in_t               in_data,
	input  logic                       cfg_we,
	input  logic [4:0]                 cfg_wdata,
	output logic [4:0]                 count,
	output logic                       push_valid,
	input  logic                       push_full,
	output logic [DEPTH-1:0][7:0]      push_vec,
	output logic [4:0]                 push_cnt
);

	localparam logic [4:0] CAP = 5'(DEPTH);

	logic [4:0]            count_q;
	logic                  busy_q;
	logic [4:0]            step_q;
	logic [7:0]            root_q;
	logic [DEPTH-1:0][7:0] gen_q;
	logic [DEPTH-1:0][7:0] preg_q;

	logic [DEPTH-1:0][7:0] shift_in;
	logic [DEPTH-1:0][7:0] prev_term;
	logic [DEPTH-1:0][7:0] lfsr_nxt;
	logic [DEPTH-1:0][7:0] gen_nxt;
	logic [7:0]            factor;
	logic                  accept;

	assign factor   = in_data.data_byte ^ preg_q[0];
	assign in_ready = !busy_q && !push_full;
	assign accept   = in_valid && in_ready;

	for (genvar j = 0; j < DEPTH; j++) begin : g_lane
		if (j < DEPTH - 1) begin : g_mid
			assign shift_in[j] = preg_q[j+1];
		end else begin : g_top
			assign shift_in[j] = 8'h00;
		end
		if (j == 0) begin : g_lead
			assign prev_term[j] = 8'h01;
		end else begin : g_rest
			assign prev_term[j] = gen_q[j-1];
		end
		assign lfsr_nxt[j] = shift_in[j] ^ rsp_pkg::gf_mul(gen_q[j], factor);
		// multiply the running product by (x - root)
		assign gen_nxt[j]  = gen_q[j] ^ rsp_pkg::gf_mul(prev_term[j], root_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= rsp_pkg::clamp_count(rsp_pkg::RESET_COUNT, CAP);
			busy_q  <= 1'b1;
			step_q  <= 5'd0;
			root_q  <= 8'h01;
			gen_q   <= '0;
			preg_q  <= '0;
		end else if (cfg_we) begin
			count_q <= rsp_pkg::clamp_count(cfg_wdata, CAP);
			busy_q  <= 1'b1;
			step_q  <= 5'd0;
			root_q  <= 8'h01;
			gen_q   <= '0;
			preg_q  <= '0;
		end else begin
			if (busy_q) begin
				gen_q  <= gen_nxt;
				root_q <= rsp_pkg::gf_xtime(root_q);
				step_q <= step_q + 5'd1;
				if (step_q == count_q - 5'd1)
					busy_q <= 1'b0;
			end
			if (accept) begin
				// drop the remainder once it is handed to the queue
				preg_q <= in_data.block_last ? '0 : lfsr_nxt;
			end
		end
	end

	assign count      = count_q;
	assign push_valid = accept && in_data.block_last;
	assign push_vec   = lfsr_nxt;
	assign push_cnt   = count_q;

	`RSP_ASSERT_NEXT(a_cfg_rebuild, cfg_we, busy_q && !in_ready, "no rebuild after count write")
	`RSP_ASSERT_NEXT(a_last_clears, push_valid, preg_q == '0, "remainder kept after last beat")
	`RSP_ASSERT_NOW(a_push_room, push_valid, !push_full, "push into full queue")

endmodule

// File: rtl/rsp_queue.sv
// ---------------------------------------------------------------------------
// RS parity encoder block queue
// Two-entry FIFO of finished remainders between front and back end.
// ---------------------------------------------------------------------------
`include "reed_solomon_parity_encoder_unit_macros.svh"

module rsp_queue #(
	parameter int WIDTH = 245
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             valid
);

	logic [1:0][WIDTH-1:0] mem_q;
	logic                  wr_q;
	logic                  rd_q;
	logic [1:0]            cnt_q;

	assign full     = cnt_q == 2'd2;
	assign valid    = cnt_q != 2'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`RSP_ASSERT_NOW(a_pop_empty, pop, valid, "pop from empty queue")

endmodule

// File: rtl/rsp_back.sv
// ---------------------------------------------------------------------------
// RS parity encoder back end
// Unloads one remainder at a time as parity beats, highest order first.
// ---------------------------------------------------------------------------
`include "reed_solomon_parity_encoder_unit_macros.svh"

module rsp_back #(
	parameter int DEPTH = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	input  logic [DEPTH-1:0][7:0] pop_vec,
	input  logic [4:0]            pop_cnt,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rsp_pkg::out_t         out_data
);

	logic [DEPTH-1:0][7:0] drain_q;
	logic [4:0]            rem_q;
	logic [DEPTH-1:0][7:0] drain_shift;
	logic                  take;

	for (genvar j = 0; j < DEPTH; j++) begin : g_drain
		if (j < DEPTH - 1) begin : g_mid
			assign drain_shift[j] = drain_q[j+1];
		end else begin : g_top
			assign drain_shift[j] = 8'h00;
		end
	end

	assign out_valid            = rem_q != 5'd0;
	assign out_data.parity_byte = drain_q[0];
	assign out_data.parity_last = rem_q == 5'd1;
	assign take                 = out_valid && out_ready;
	// refill as the final beat leaves so blocks run without a gap
	assign pop = pop_valid && (rem_q == 5'd0 || (rem_q == 5'd1 && take));

	always_ff @(posedge clk) begin
		if (pop)
			drain_q <= pop_vec;
		else if (take)
			drain_q <= drain_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 5'd0;
		end else if (pop) begin
			rem_q <= pop_cnt;
		end else if (take) begin
			rem_q <= rem_q - 5'd1;
		end
	end

	`RSP_ASSERT_NEXT(a_rem_step, take && rem_q > 5'd1, rem_q == 5'($past(rem_q) - 5'd1),
		"parity count did not step")
	`RSP_ASSERT_NOW(a_rem_cap, out_valid, rem_q <= 5'(DEPTH), "parity count above depth")

endmodule

// File: tb/reed_solomon_parity_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the RS parity encoder unit
// Streams data bytes in blocks through the encoder under several parity
// counts, predicts the parity bytes with a GF(256) LFSR of its own and
// compares every output beat in order. Both channels idle at random, the
// receiver holds off once for a long stretch, and parity_count is rewritten
// over APB between phases, including out-of-range and mid-block writes.
// ---------------------------------------------------------------------------
module reed_solomon_parity_encoder_unit_tb;

	localparam int COUNT_MAX     = rsp_pkg::COUNT_LIMIT;
	localparam int SPARE_REG     = 1;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD     = 400;
	localparam int IDLE_LIMIT    = 5000;

	logic          clk;
	logic          arst_n   = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	rsp_pkg::in_t  in_data  = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	rsp_pkg::out_t out_data;
	logic          psel     = 1'b0;
	logic          penable  = 1'b0;
	logic          pwrite   = 1'b0;
	logic [2:0]    paddr    = '0;
	logic [31:0]   pwdata   = '0;
	logic [31:0]   prdata;
	logic          pready;

	// stimulus control, written only by the stimulus process
	logic random_phase = 1'b0;
	logic no_idle      = 1'b0;

	rsp_pkg::in_t  data_beats[$];
	rsp_pkg::out_t parity_due[$];
	int            mismatches = 0;

	// predictor state
	int         model_count;
	logic [7:0] remainder[0:COUNT_MAX-1];
	logic [7:0] gen_coef[0:COUNT_MAX-1];

	int send_wait;
	int ready_wait;
	int hold_left;
	logic hold_done;
	int idle_cycles;

	reed_solomon_parity_encoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
		logic [8:0] x;
		logic [7:0] acc;
		int i;
		acc = 8'h00;
		x = {1'b0, a};
		for (i = 0; i < 8; i++) begin
			if (b[i])
				acc = acc ^ x[7:0];
			x = x << 1;
			if (x[8])
				x = x ^ rsp_pkg::FIELD_POLY;
		end
		return acc;
	endfunction

	// g(x) = prod (x - alpha^i), i = 0..n-1; keep all but the leading 1
	function automatic void rebuild_generator(int n);
		logic [7:0] poly[0:COUNT_MAX];
		logic [7:0] root;
		int i;
		int j;
		for (i = 0; i <= COUNT_MAX; i++)
			poly[i] = 8'h00;
		poly[0] = 8'h01;
		root = 8'h01;
		for (i = 0; i < n; i++) begin
			for (j = i + 1; j >= 1; j--)
				poly[j] = poly[j] ^ gf_times(poly[j-1], root);
			root = gf_times(root, 8'h02);
		end
		for (i = 0; i < COUNT_MAX; i++)
			gen_coef[i] = (i < n) ? poly[i+1] : 8'h00;
	endfunction

	function automatic void clear_remainder();
		int i;
		for (i = 0; i < COUNT_MAX; i++)
			remainder[i] = 8'h00;
	endfunction

	function automatic void apply_reg_write(int idx, logic [31:0] value);
		int n;
		if (idx != int'(rsp_pkg::REG_PARITY_COUNT))
			return;
		n = int'(value[4:0]);
		if (n < 1)
			n = 1;
		if (n > COUNT_MAX)
			n = COUNT_MAX;
		model_count = n;
		clear_remainder();
		rebuild_generator(n);
	endfunction

	// shift one data byte through the LFSR; on the last byte queue the parity
	function automatic void encode_beat(rsp_pkg::in_t beat);
		logic [7:0] factor;
		rsp_pkg::out_t r;
		int j;
		factor = beat.data_byte ^ remainder[0];
		for (j = 0; j + 1 < model_count; j++)
			remainder[j] = remainder[j+1];
		remainder[model_count-1] = 8'h00;
		for (j = 0; j < model_count; j++)
			remainder[j] = remainder[j] ^ gf_times(gen_coef[j], factor);
		if (beat.block_last) begin
			for (j = 0; j < model_count; j++) begin
				r.parity_byte = remainder[j];
				r.parity_last = (j == model_count - 1);
				parity_due.insert(parity_due.size(), r);
			end
			clear_remainder();
		end
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	initial begin
		model_count = int'(rsp_pkg::RESET_COUNT);
		clear_remainder();
		rebuild_generator(model_count);
	end

	// driver: present queued data beats, with random gaps after each one
	always @(posedge clk or negedge arst_n) begin : drive_data
		int g;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_wait <= 0;
		end else begin
			if (in_valid && in_ready) begin
				encode_beat(in_data);
				g = no_idle ? 0 : draw_gap();
				if (g == 0 && data_beats.size() > 0) begin
					in_data <= data_beats.pop_front();
				end else begin
					in_valid <= 1'b0;
					send_wait <= g;
				end
			end else if (!in_valid) begin
				if (send_wait > 0)
					send_wait <= send_wait - 1;
				else if (data_beats.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= data_beats.pop_front();
				end
			end
		end
	end

	// monitor: check parity beats in order and pace out_ready
	always @(posedge clk or negedge arst_n) begin : check_parity
		rsp_pkg::out_t want;
		int g;
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_wait <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (parity_due.size() == 0) begin
					$display("%0t ns: unexpected parity beat: expected none, actual %02h/%0b",
						$time, out_data.parity_byte, out_data.parity_last);
					mismatches <= mismatches + 1;
				end else begin
					want = parity_due.pop_front();
					if (out_data.parity_byte !== want.parity_byte) begin
						$display("%0t ns: parity_byte mismatch: expected %02h, actual %02h",
							$time, want.parity_byte, out_data.parity_byte);
						mismatches <= mismatches + 1;
					end else if (out_data.parity_last !== want.parity_last) begin
						$display("%0t ns: parity_last mismatch: expected %0b, actual %0b",
							$time, want.parity_last, out_data.parity_last);
						mismatches <= mismatches + 1;
					end
				end
			end
			// hold off once for a long stretch so the encoder backs up
			if (random_phase && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= (hold_left == 1);
			end else if (out_valid && out_ready) begin
				g = no_idle ? 0 : draw_gap();
				ready_wait <= g;
				out_ready <= (g == 0);
			end else if (ready_wait > 0) begin
				ready_wait <= ready_wait - 1;
				out_ready <= (ready_wait == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic push_beat(logic [7:0] d, logic last);
		rsp_pkg::in_t b;
		b.data_byte = d;
		b.block_last = last;
		data_beats.insert(data_beats.size(), b);
	endtask

	// queue random blocks; the final block is closed if close is set, else only if it happens to end there
	task automatic queue_blocks(int beats, bit close);
		int left;
		int i;
		left = 0;
		for (i = 0; i < beats; i++) begin
			if (left == 0)
				left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
					: $urandom_range(1, 6);
			left--;
			push_beat(8'($urandom()), (left == 0) || (close && i == beats - 1));
			if (i == beats - 1 && close)
				left = 0;
		end
	endtask

	// wait until every beat is sent and every parity beat has come back
	task automatic settle();
		do
			@(posedge clk);
		while (data_beats.size() != 0 || in_valid || parity_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * idx);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		apply_reg_write(idx, value);
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset count: all-zero block, extremes, single full byte
		push_beat(8'h00, 1'b1);
		push_beat(8'hFF, 1'b0);
		push_beat(8'h80, 1'b0);
		push_beat(8'h01, 1'b0);
		push_beat(8'h7F, 1'b0);
		push_beat(8'hAA, 1'b1);
		push_beat(8'hFF, 1'b1);
		settle();

		// zero acts as one
		write_reg(int'(rsp_pkg::REG_PARITY_COUNT), 32'd0);
		push_beat(8'h55, 1'b0);
		push_beat(8'hFF, 1'b1);
		settle();

		// above the limit saturates
		write_reg(int'(rsp_pkg::REG_PARITY_COUNT), 32'd31);
		push_beat(8'h01, 1'b0);
		push_beat(8'hFE, 1'b0);
		push_beat(8'h80, 1'b1);
		settle();

		// unknown register: count stays at its value
		write_reg(SPARE_REG, 32'd3);
		push_beat(8'h33, 1'b0);
		push_beat(8'hCC, 1'b1);
		settle();

		// rewrite mid-block: upper bits ignored, open block dropped
		push_beat(8'h12, 1'b0);
		push_beat(8'hED, 1'b0);
		push_beat(8'h00, 1'b0);
		settle();
		write_reg(int'(rsp_pkg::REG_PARITY_COUNT), 32'hFFFF_FF07);
		push_beat(8'h40, 1'b0);
		push_beat(8'hBF, 1'b0);
		push_beat(8'h02, 1'b0);
		push_beat(8'hFD, 1'b1);
		settle();

		// random phases; short blocks first so the held receiver backs up the input
		write_reg(int'(rsp_pkg::REG_PARITY_COUNT), 32'd16);
		@(posedge clk);
		random_phase <= 1'b1;
		push_beat(8'h9C, 1'b1);
		push_beat(8'h3E, 1'b1);
		push_beat(8'hD1, 1'b1);
		push_beat(8'h07, 1'b1);
		queue_blocks(18, 1'b1);
		settle();

		write_reg(int'(rsp_pkg::REG_PARITY_COUNT), 32'd1);
		queue_blocks(16, 1'b0);
		settle();

		write_reg(int'(rsp_pkg::REG_PARITY_COUNT), 32'd30);
		@(posedge clk);
		no_idle <= 1'b1;
		queue_blocks(18, 1'b1);
		settle();
		no_idle <= 1'b0;

		write_reg(int'(rsp_pkg::REG_PARITY_COUNT), $urandom_range(1, 30));
		queue_blocks(16, 1'b1);
		settle();

		write_reg(int'(rsp_pkg::REG_PARITY_COUNT), $urandom());
		queue_blocks(18, 1'b1);
		settle();

		if (mismatches == 0 && parity_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rsp_pkg.sv
rtl/rsp_front.sv
rtl/rsp_queue.sv
rtl/rsp_back.sv
rtl/reed_solomon_parity_encoder_unit.sv
tb/reed_solomon_parity_encoder_unit_tb.sv
